// File: sv/aet_pkg.sv
// Shared types and constants for the arithmetic expression tokenizer.
// Token kind and class codes, character codes and the result entry type.
// No dependencies.
`default_nettype none

package aet_pkg;

    localparam int MAX_DIGITS   = 9;
    localparam int VALUE_BITS   = 32;
    localparam int NUMBER_W     = 32;
    localparam int KIND_W       = 4;
    localparam int CHAR_W       = 8;
    localparam int DIGIT_CNT_W  = 4;

    typedef enum logic [KIND_W-1:0] {
        TK_NUMBER = 4'd0,
        TK_ADD    = 4'd1,
        TK_SUB    = 4'd2,
        TK_MUL    = 4'd3,
        TK_DIV    = 4'd4,
        TK_POW    = 4'd5,
        TK_LPAREN = 4'd6,
        TK_RPAREN = 4'd7,
        TK_END    = 4'd8,
        TK_ERROR  = 4'd9
    } token_kind_t;

    typedef enum logic [1:0] {
        CLS_NONE   = 2'd0,
        CLS_LPAREN = 2'd1,
        CLS_OTHER  = 2'd2
    } token_class_t;

    typedef enum logic {
        OP_CHAR = 1'b0,
        OP_END  = 1'b1
    } operation_t;

    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_CARET  = 8'h5E;
    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;

    typedef struct packed {
        token_kind_t          kind;
        logic [NUMBER_W-1:0]  value;
        logic                 last;
    } token_t;

endpackage

`default_nettype wire

// File: sv/arith_expression_tokenizer.sv
// Streaming lexer for integer arithmetic expressions, one character per request.
// An input request passes the input register, then the token register, before its first token appears.
// Throughput: one request per cycle while m_axis_tready is high; a request yielding two tokens
// stalls the next request while the second token drains from the token register pair.
// Reset (rst_n low, async): lexer state cleared, input and token registers empty.
// Depends on aet_pkg.
`default_nettype none

module arith_expression_tokenizer
    import aet_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [CHAR_W-1:0]   s_axis_tdata,   // [7:0] character
    input  wire logic [0:0]          s_axis_tuser,   // [0] operation
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic [NUMBER_W-1:0]      m_axis_tdata,   // [31:0] number_value
    output logic [KIND_W-1:0]        m_axis_tuser,   // [3:0] token_kind
    output logic                     m_axis_tlast    // last_of_run
);

    // input register
    logic                   in_valid_reg, in_valid_next;
    logic [CHAR_W-1:0]      in_char_reg;
    operation_t             in_op_reg;

    // lexer state
    logic [VALUE_BITS-1:0]  acc_reg, acc_next;
    logic [DIGIT_CNT_W-1:0] dcnt_reg, dcnt_next;
    token_class_t           cls_reg, cls_next;
    logic                   err_reg, err_next;

    // token register pair
    logic   res0_valid_reg, res0_valid_next;
    logic   res1_valid_reg, res1_valid_next;
    token_t res0_reg, res0_next;
    token_t res1_reg, res1_next;

    logic        free_slots;
    logic        consume;
    logic        out_take;

    // per-item decode
    logic                  pre_valid;
    logic [NUMBER_W-1:0]   pre_value;
    logic                  main_valid;
    token_kind_t           main_kind;
    token_kind_t           op_kind;
    logic                  is_digit;
    logic                  flush;
    token_class_t          cls_eff;
    logic [VALUE_BITS-1:0] acc_times10;
    token_t                tok0, tok1;

    assign out_take      = res0_valid_reg && m_axis_tready;
    assign free_slots    = !res1_valid_reg && (!res0_valid_reg || m_axis_tready);
    assign consume       = in_valid_reg && free_slots;
    assign s_axis_tready = !in_valid_reg || consume;

    assign is_digit    = (in_char_reg >= CH_ZERO) && (in_char_reg <= CH_NINE);
    assign flush       = (dcnt_reg != '0);
    assign acc_times10 = (acc_reg << 3) + (acc_reg << 1);

    always_comb
    begin
        case (in_char_reg)
            CH_PLUS:   op_kind = TK_ADD;
            CH_MINUS:  op_kind = TK_SUB;
            CH_STAR:   op_kind = TK_MUL;
            CH_SLASH:  op_kind = TK_DIV;
            CH_CARET:  op_kind = TK_POW;
            CH_LPAREN: op_kind = TK_LPAREN;
            CH_RPAREN: op_kind = TK_RPAREN;
            default:   op_kind = TK_ERROR;
        endcase
    end

    always_comb
    begin
        acc_next   = acc_reg;
        dcnt_next  = dcnt_reg;
        cls_next   = cls_reg;
        err_next   = err_reg;
        pre_valid  = 1'b0;
        pre_value  = NUMBER_W'(acc_reg);
        main_valid = 1'b0;
        main_kind  = TK_END;
        cls_eff    = flush ? CLS_OTHER : cls_reg;

        if (consume)
        begin
            if (in_op_reg == OP_END)
            begin
                if (!err_reg)
                begin
                    pre_valid  = flush;
                    main_valid = 1'b1;
                    main_kind  = TK_END;
                end
                acc_next  = '0;
                dcnt_next = '0;
                cls_next  = CLS_NONE;
                err_next  = 1'b0;
            end
            else if (err_reg)
            begin
                // swallow characters until the end request
            end
            else if (in_char_reg == CH_SPACE || in_char_reg == CH_TAB)
            begin
                pre_valid = flush;
                if (flush)
                begin
                    acc_next  = '0;
                    dcnt_next = '0;
                    cls_next  = CLS_OTHER;
                end
            end
            else if (is_digit)
            begin
                if (dcnt_reg >= DIGIT_CNT_W'(MAX_DIGITS))
                begin
                    // pending number is dropped
                    acc_next   = '0;
                    dcnt_next  = '0;
                    err_next   = 1'b1;
                    main_valid = 1'b1;
                    main_kind  = TK_ERROR;
                end
                else
                begin
                    acc_next  = acc_times10 + VALUE_BITS'(in_char_reg[3:0]);
                    dcnt_next = dcnt_reg + 1'b1;
                    cls_next  = CLS_OTHER;
                end
            end
            else
            begin
                acc_next   = '0;
                dcnt_next  = '0;
                main_valid = 1'b1;
                main_kind  = op_kind;
                if (flush)
                begin
                    pre_valid = 1'b1;
                end
                else if (op_kind == TK_SUB && cls_eff != CLS_OTHER)
                begin
                    // unary minus becomes 0 - x
                    pre_valid = 1'b1;
                    pre_value = '0;
                end
                if (op_kind == TK_ERROR)
                begin
                    err_next = 1'b1;
                end
                cls_next = (op_kind == TK_LPAREN) ? CLS_LPAREN : CLS_OTHER;
            end
        end
    end

    always_comb
    begin
        tok1.kind  = main_kind;
        tok1.value = '0;
        tok1.last  = 1'b1;
        if (pre_valid)
        begin
            tok0.kind  = TK_NUMBER;
            tok0.value = pre_value;
            tok0.last  = !main_valid;
        end
        else
        begin
            tok0 = tok1;
        end
    end

    always_comb
    begin
        in_valid_next   = in_valid_reg;
        res0_valid_next = res0_valid_reg;
        res1_valid_next = res1_valid_reg;
        res0_next       = res0_reg;
        res1_next       = res1_reg;

        if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (consume)
        begin
            in_valid_next = 1'b0;
        end

        if (out_take)
        begin
            res0_valid_next = res1_valid_reg;
            res0_next       = res1_reg;
            res1_valid_next = 1'b0;
        end

        // consume only happens with both slots free after this cycle's take
        if (pre_valid || main_valid)
        begin
            res0_valid_next = 1'b1;
            res0_next       = tok0;
            res1_valid_next = pre_valid && main_valid;
            res1_next       = tok1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            acc_reg        <= '0;
            dcnt_reg       <= '0;
            cls_reg        <= CLS_NONE;
            err_reg        <= 1'b0;
            res0_valid_reg <= 1'b0;
            res1_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            acc_reg        <= acc_next;
            dcnt_reg       <= dcnt_next;
            cls_reg        <= cls_next;
            err_reg        <= err_next;
            res0_valid_reg <= res0_valid_next;
            res1_valid_reg <= res1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_char_reg <= s_axis_tdata;
            in_op_reg   <= operation_t'(s_axis_tuser[0]);
        end
        res0_reg <= res0_next;
        res1_reg <= res1_next;
    end

    assign m_axis_tvalid = res0_valid_reg;
    assign m_axis_tdata  = res0_reg.value;
    assign m_axis_tuser  = res0_reg.kind;
    assign m_axis_tlast  = res0_reg.last;

    // second slot only ever holds the tail of a pair behind its head
    assert property (@(posedge clk) disable iff (!rst_n)
        res1_valid_reg |-> (res0_valid_reg && !res0_reg.last && res1_reg.last))
        else $error("token pair order broken");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != TK_NUMBER) |-> (m_axis_tdata == '0))
        else $error("non-number token carries a value");

    assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |-> (dcnt_reg == '0 && acc_reg == '0))
        else $error("number pending after error");

    assert property (@(posedge clk) disable iff (!rst_n)
        (dcnt_reg != '0) |-> (cls_reg == CLS_OTHER && dcnt_reg <= DIGIT_CNT_W'(MAX_DIGITS)))
        else $error("digit count or class inconsistent");

endmodule

`default_nettype wire
